// ===== hw/rtl/hdlcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hdlcd_pkg - shared definitions for the async hdlc deframer
// Byte codes, crc-16/x.25 constants, result codes and field widths.
// ----------------------------------------------------------------------------
package hdlcd_pkg;

   // field widths
   localparam int BYTE_W = 8;
   localparam int CRC_W  = 16;
   localparam int LEN_W  = 13;
   localparam int STAT_W = 3;

   // default frame size limit
   localparam int MAX_FRAME_BYTES_DEF = 4096;

   // framing byte codes
   localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
   localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
   localparam logic [BYTE_W-1:0] ESC_MASK  = 8'h20;

   // crc-16/x.25, reflected
   localparam logic [CRC_W-1:0] CRC_INIT      = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY_REFL = 16'h8408;
   localparam logic [CRC_W-1:0] CRC_GOOD      = 16'hF0B8;

   // result kind
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // end of frame status codes
   typedef enum logic [STAT_W-1:0] {
      ST_GOOD      = 3'd0,
      ST_CRC_ERROR = 3'd1,
      ST_TOO_SHORT = 3'd2,
      ST_OVERFLOW  = 3'd3,
      ST_ABORTED   = 3'd4
   } status_type;

endpackage

// ===== hw/rtl/hdlcd_crc16_step.sv =====
// ----------------------------------------------------------------------------
// hdlcd_crc16_step - one byte of crc-16/x.25
// Folds one byte into the reflected crc accumulator, lsb first.
// ----------------------------------------------------------------------------
module hdlcd_crc16_step
   import hdlcd_pkg::*;
(
   input  logic [CRC_W-1:0]  crc_in,
   input  logic [BYTE_W-1:0] data_in,
   output logic [CRC_W-1:0]  crc_out
);

   // eight shift and conditional xor steps
   always_comb begin
      logic [CRC_W-1:0] c;
      c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      crc_out = c;
   end

endmodule

// ===== hw/rtl/async_hdlc_deframer_fcs16_unit.sv =====
// latency: a result appears in the cycle after its input byte is accepted
// throughput: one byte per cycle while req_ready is high; the crc step feeds
//    back into the frame state registers, the hold logic into the result register
// req_ready drops only while a result waits in the result register
// reset (synchronous): crc to 0xffff, counters and flags cleared, result empty
// ----------------------------------------------------------------------------
// async_hdlc_deframer_fcs16_unit - async hdlc receive deframer
// Splits flag-delimited frames, removes escapes, holds back the fcs and
// reports payload bytes and an end of frame status.
// ----------------------------------------------------------------------------
module async_hdlc_deframer_fcs16_unit
   import hdlcd_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [BYTE_W-1:0] rsp_data_byte,
   output logic              rsp_last,
   output logic [STAT_W-1:0] rsp_status,
   output logic [LEN_W-1:0]  rsp_frame_length
);

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

   // frame state
   logic             esc_ff, esc_in;
   logic [CRC_W-1:0] crc_ff, crc_in;
   logic [1:0]       held_cnt_ff, held_cnt_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [BYTE_W-1:0] held0_ff, held0_in;
   logic [BYTE_W-1:0] held1_ff, held1_in;

   // result register
   logic              rsp_valid_ff;
   logic              kind_ff, kind_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              last_ff, last_in;
   status_type        status_ff, status_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   logic              res_valid;
   logic              accept;
   logic [BYTE_W-1:0] plain_byte;
   logic [CRC_W-1:0]  crc_next;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // unescaped byte
   assign plain_byte = esc_ff ? (req_rx_byte ^ ESC_MASK) : req_rx_byte;

   hdlcd_crc16_step u_crc (
      .crc_in  (crc_ff),
      .data_in (plain_byte),
      .crc_out (crc_next)
   );

   // next frame state and result
   always_comb begin
      esc_in      = esc_ff;
      crc_in      = crc_ff;
      held_cnt_in = held_cnt_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      held0_in    = held0_ff;
      held1_in    = held1_ff;
      res_valid   = 1'b0;
      kind_in     = KIND_DATA;
      data_in     = '0;
      last_in     = 1'b0;
      status_in   = ST_GOOD;
      len_in      = '0;

      if (req_rx_byte == FLAG_BYTE) begin
         if (esc_ff || held_cnt_ff != 2'd0 || count_ff != '0 || ovf_ff) begin
            res_valid = 1'b1;
            kind_in   = KIND_END;
            last_in   = 1'b1;
            len_in    = LEN_W'(count_ff);
            if (esc_ff) begin
               status_in = ST_ABORTED;
            end else if (ovf_ff) begin
               status_in = ST_OVERFLOW;
            end else if (!held_cnt_ff[1]) begin
               status_in = ST_TOO_SHORT;
            end else if (crc_ff == CRC_GOOD) begin
               status_in = ST_GOOD;
            end else begin
               status_in = ST_CRC_ERROR;
            end
            // back to idle frame state
            esc_in      = 1'b0;
            crc_in      = CRC_INIT;
            held_cnt_in = 2'd0;
            count_in    = '0;
            ovf_in      = 1'b0;
         end
      end else if (!esc_ff && req_rx_byte == ESC_BYTE) begin
         esc_in = 1'b1;
      end else begin
         esc_in = 1'b0;
         crc_in = crc_next;
         if (!held_cnt_ff[1]) begin
            // filling the fcs hold registers
            if (held_cnt_ff[0]) begin
               held1_in = plain_byte;
            end else begin
               held0_in = plain_byte;
            end
            held_cnt_in = held_cnt_ff + 2'd1;
         end else begin
            held0_in = held1_ff;
            held1_in = plain_byte;
            if (ovf_ff || count_ff >= CNT_MAX) begin
               ovf_in = 1'b1;
            end else begin
               count_in  = count_ff + CNT_W'(1);
               res_valid = 1'b1;
               data_in   = held0_ff;
            end
         end
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff      <= 1'b0;
         crc_ff      <= CRC_INIT;
         held_cnt_ff <= 2'd0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
      end else if (accept) begin
         esc_ff      <= esc_in;
         crc_ff      <= crc_in;
         held_cnt_ff <= held_cnt_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
      end
   end

   // fcs hold registers
   always_ff @(posedge clock) begin
      if (accept) begin
         held0_ff <= held0_in;
         held1_ff <= held1_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= res_valid;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         kind_ff   <= kind_in;
         data_ff   <= data_in;
         last_ff   <= last_in;
         status_ff <= status_in;
         len_ff    <= len_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_last         = last_ff;
   assign rsp_status       = status_ff;
   assign rsp_frame_length = len_ff;

endmodule

// ===== hw/rtl/hdlcd_checker.sv =====
// ----------------------------------------------------------------------------
// hdlcd_checker - port level checks for the hdlc deframer
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module hdlcd_checker
   import hdlcd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [BYTE_W-1:0] req_rx_byte,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_kind,
   input logic [BYTE_W-1:0] rsp_data_byte,
   input logic              rsp_last,
   input logic [STAT_W-1:0] rsp_status,
   input logic [LEN_W-1:0]  rsp_frame_length
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_status) && $stable(rsp_frame_length) && $stable(rsp_last))
      else $error("result changed while stalled");

   // end of frame results carry kind and last together, data zero
   a_end_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == rsp_last) && (!rsp_last || rsp_data_byte == '0))
      else $error("kind and last disagree");

   // data results carry no status or length
   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == ST_GOOD && rsp_frame_length == '0)
      else $error("data result with status or length");

   // only a flag byte can close a frame
   a_end_after_flag: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_rx_byte != FLAG_BYTE |=> !(rsp_valid && rsp_last))
      else $error("end of frame without a flag");

endmodule

bind async_hdlc_deframer_fcs16_unit hdlcd_checker u_hdlcd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_rx_byte      (req_rx_byte),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_data_byte    (rsp_data_byte),
   .rsp_last         (rsp_last),
   .rsp_status       (rsp_status),
   .rsp_frame_length (rsp_frame_length)
);
